@@ rtl/core/lcrt_pkg.sv @@
// Shared types and constants for the line change record totaler.
package lcrt_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned COUNT_W     = 64;
    localparam int unsigned OUT_TDATA_W = 136;

    localparam logic [BYTE_W-1:0] BYTE_TAB  = 8'h09;
    localparam logic [BYTE_W-1:0] BYTE_NUL  = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_DASH = 8'h2D;
    localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] BYTE_NINE = 8'h39;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [1:0] LEN_MAX = 2'd3;

    typedef enum logic [2:0] {
        PH_CNT_A       = 3'd0,
        PH_CNT_B       = 3'd1,
        PH_PATH_START  = 3'd2,
        PH_PATH_BODY   = 3'd3,
        PH_SKIP1_START = 3'd4,
        PH_SKIP1_BODY  = 3'd5,
        PH_SKIP2_START = 3'd6,
        PH_SKIP2_BODY  = 3'd7
    } t_phase;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] added_lines;
        logic [COUNT_W-1:0] deleted_lines;
        logic               binary_seen;
    } t_result;

endpackage

@@ rtl/core/line_change_record_totaler.sv @@
// Line change record totaler top level: input register, parser, result register.
// Takes one item per cycle on the input stream while no end-of-output item waits.
// An item is registered, then updates the parser state; an end-of-output item loads the
// result register with the current result and clears the totals at once, so
// the next record stream can follow in the very next cycle. An end-of-output item
// waits in the input register only while an earlier result is still held unread in
// the result register; data byte items never wait on the output themselves, but
// queue behind such a waiting end-of-output item.
module line_change_record_totaler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lcrt_pkg::BYTE_W-1:0]         s_axis_tdata,  // [7:0] data_byte
    input  logic [0:0]                          s_axis_tuser,  // [0] op
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] ok, [64:1] added_lines, [128:65] deleted_lines, [129] binary_seen, rest zero
    output logic [lcrt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import lcrt_pkg::*;

    logic              r_in_valid;
    logic              r_in_op;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           result;
    logic              go;

    assign go            = r_in_valid && ((r_in_op == OP_BYTE) || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser[0];
            r_in_byte <= s_axis_tdata;
        end
    end

    lcrt_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_op     (r_in_op),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && (r_in_op == OP_END)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && (r_in_op == OP_END)) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2 * COUNT_W - 2){1'b0}}, r_out.binary_seen,
                            r_out.deleted_lines, r_out.added_lines, r_out.ok};

endmodule

@@ rtl/core/lcrt_parse.sv @@
// Record parser: per-item state update and running totals.
module lcrt_parse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic                          i_op,
    input  logic [lcrt_pkg::BYTE_W-1:0]   i_byte,
    output lcrt_pkg::t_result             o_result
);
    import lcrt_pkg::*;

    t_phase             r_phase,     n_phase;
    logic [1:0]         r_len,       n_len;
    logic [COUNT_W-1:0] r_num,       n_num;
    logic               r_dash,      n_dash;
    logic               r_bad,       n_bad;
    logic [COUNT_W-1:0] r_first_num, n_first_num;
    logic               r_first_dash, n_first_dash;
    logic               r_first_bad, n_first_bad;
    logic [COUNT_W-1:0] r_add_sum,   n_add_sum;
    logic [COUNT_W-1:0] r_del_sum,   n_del_sum;
    logic               r_bin,       n_bin;
    logic               r_err,       n_err;

    logic               is_digit;
    logic [3:0]         digit;
    logic [COUNT_W+3:0] prod;
    logic [1:0]         cnt_len;
    logic [COUNT_W-1:0] cnt_num;
    logic               cnt_dash;
    logic               cnt_bad;
    logic               dash_b;
    logic [COUNT_W:0]   sum_a;
    logic [COUNT_W:0]   sum_d;
    logic               ok;

    always_comb begin
        is_digit = (i_byte >= BYTE_ZERO) && (i_byte <= BYTE_NINE);
        digit    = 4'(i_byte - BYTE_ZERO);
        // times ten plus digit, with four guard bits for overflow
        prod     = ({4'b0, r_num} << 3) + ({4'b0, r_num} << 1) + {{COUNT_W{1'b0}}, digit};

        cnt_dash = r_dash | ((r_len == 2'd0) && (i_byte == BYTE_DASH));
        cnt_len  = (r_len == LEN_MAX) ? LEN_MAX : r_len + 2'd1;
        cnt_num  = r_num;
        cnt_bad  = r_bad;
        if (is_digit) begin
            if (!r_bad) begin
                if (prod[COUNT_W+3:COUNT_W] != 4'd0) begin
                    cnt_bad = 1'b1;
                end else begin
                    cnt_num = prod[COUNT_W-1:0];
                end
            end
        end else begin
            cnt_bad = 1'b1;
        end

        dash_b = (r_len == 2'd1) && r_dash;
        sum_a  = {1'b0, r_add_sum} + {1'b0, r_first_num};
        sum_d  = {1'b0, r_del_sum} + {1'b0, r_num};

        n_phase      = r_phase;
        n_len        = r_len;
        n_num        = r_num;
        n_dash       = r_dash;
        n_bad        = r_bad;
        n_first_num  = r_first_num;
        n_first_dash = r_first_dash;
        n_first_bad  = r_first_bad;
        n_add_sum    = r_add_sum;
        n_del_sum    = r_del_sum;
        n_bin        = r_bin;
        n_err        = r_err;

        case (r_phase)
            PH_CNT_A: begin
                if (i_byte == BYTE_NUL) begin
                    n_err  = 1'b1;
                    n_len  = 2'd0;
                    n_num  = '0;
                    n_dash = 1'b0;
                    n_bad  = 1'b0;
                end else if (i_byte == BYTE_TAB) begin
                    if (r_len == 2'd0) begin
                        n_err = 1'b1;
                    end
                    n_first_num  = r_num;
                    n_first_dash = dash_b;
                    n_first_bad  = r_bad;
                    n_len        = 2'd0;
                    n_num        = '0;
                    n_dash       = 1'b0;
                    n_bad        = 1'b0;
                    n_phase      = PH_CNT_B;
                end else begin
                    n_len  = cnt_len;
                    n_num  = cnt_num;
                    n_dash = cnt_dash;
                    n_bad  = cnt_bad;
                end
            end
            PH_CNT_B: begin
                if (i_byte == BYTE_NUL) begin
                    n_err   = 1'b1;
                    n_len   = 2'd0;
                    n_num   = '0;
                    n_dash  = 1'b0;
                    n_bad   = 1'b0;
                    n_phase = PH_CNT_A;
                end else if (i_byte == BYTE_TAB) begin
                    if (r_len == 2'd0) begin
                        n_err = 1'b1;
                    end else if (r_first_dash || dash_b) begin
                        if (r_first_dash && dash_b) begin
                            n_bin = 1'b1;
                        end else begin
                            n_err = 1'b1;
                        end
                    end else if (r_first_bad || r_bad) begin
                        n_err = 1'b1;
                    end else if (sum_a[COUNT_W] || sum_d[COUNT_W]) begin
                        n_err = 1'b1;
                    end else begin
                        n_add_sum = sum_a[COUNT_W-1:0];
                        n_del_sum = sum_d[COUNT_W-1:0];
                    end
                    n_len   = 2'd0;
                    n_num   = '0;
                    n_dash  = 1'b0;
                    n_bad   = 1'b0;
                    n_phase = PH_PATH_START;
                end else begin
                    n_len  = cnt_len;
                    n_num  = cnt_num;
                    n_dash = cnt_dash;
                    n_bad  = cnt_bad;
                end
            end
            PH_PATH_START: begin
                n_phase = (i_byte == BYTE_NUL) ? PH_SKIP1_START : PH_PATH_BODY;
            end
            PH_PATH_BODY: begin
                if (i_byte == BYTE_NUL) begin
                    n_phase = PH_CNT_A;
                end
            end
            PH_SKIP1_START: begin
                if (i_byte == BYTE_NUL) begin
                    n_err   = 1'b1;
                    n_phase = PH_CNT_A;
                end else begin
                    n_phase = PH_SKIP1_BODY;
                end
            end
            PH_SKIP1_BODY: begin
                if (i_byte == BYTE_NUL) begin
                    n_phase = PH_SKIP2_START;
                end
            end
            PH_SKIP2_START: begin
                if (i_byte == BYTE_NUL) begin
                    n_err   = 1'b1;
                    n_phase = PH_CNT_A;
                end else begin
                    n_phase = PH_SKIP2_BODY;
                end
            end
            PH_SKIP2_BODY: begin
                if (i_byte == BYTE_NUL) begin
                    n_phase = PH_CNT_A;
                end
            end
            default: begin
                n_phase = PH_CNT_A;
            end
        endcase

        // end of output: result is taken from the current state, then all clears
        if (i_op == OP_END) begin
            n_phase      = PH_CNT_A;
            n_len        = 2'd0;
            n_num        = '0;
            n_dash       = 1'b0;
            n_bad        = 1'b0;
            n_first_num  = '0;
            n_first_dash = 1'b0;
            n_first_bad  = 1'b0;
            n_add_sum    = '0;
            n_del_sum    = '0;
            n_bin        = 1'b0;
            n_err        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_CNT_A;
            r_len        <= 2'd0;
            r_num        <= '0;
            r_dash       <= 1'b0;
            r_bad        <= 1'b0;
            r_first_num  <= '0;
            r_first_dash <= 1'b0;
            r_first_bad  <= 1'b0;
            r_add_sum    <= '0;
            r_del_sum    <= '0;
            r_bin        <= 1'b0;
            r_err        <= 1'b0;
        end else if (i_go) begin
            r_phase      <= n_phase;
            r_len        <= n_len;
            r_num        <= n_num;
            r_dash       <= n_dash;
            r_bad        <= n_bad;
            r_first_num  <= n_first_num;
            r_first_dash <= n_first_dash;
            r_first_bad  <= n_first_bad;
            r_add_sum    <= n_add_sum;
            r_del_sum    <= n_del_sum;
            r_bin        <= n_bin;
            r_err        <= n_err;
        end
    end

    assign ok = !r_err && (r_phase == PH_CNT_A) && (r_len == 2'd0);

    assign o_result.ok            = ok;
    assign o_result.added_lines   = ok ? r_add_sum : '0;
    assign o_result.deleted_lines = ok ? r_del_sum : '0;
    assign o_result.binary_seen   = ok && r_bin;

endmodule
